// ===== rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants, register codes and pipeline types of the terrain pixel
// shader.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int NUM_BANDS       = 6;
    localparam int SHADES_PER_BAND = 40;
    localparam int BAND_BASE_INDEX = 4;
    localparam int SEA_LIT_INDEX   = 2;
    localparam int SEA_UNLIT_INDEX = 3;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SEA_LEVEL       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_VARIANCE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONTOUR_WEIGHT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHADE_CONTRAST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_COS       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_SIN       = 3'd5;

    localparam int BAND_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int NB_W    = $clog2(NUM_BANDS + 1);
    localparam int SHADE_W = (SHADES_PER_BAND > 1) ? $clog2(SHADES_PER_BAND) : 1;
    localparam int SPB_W   = $clog2(SHADES_PER_BAND + 1);

    localparam int D_W        = 50;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 34;
    localparam int SQRT_STEPS = 32;
    localparam int DIVD_W     = 64;
    localparam int DIV_STEPS  = 48;
    localparam int DREM_W     = 50;
    localparam int NM_W       = 47;
    localparam int PROD_W     = 63;
    localparam int VC_W       = 47;
    localparam int EFF_W      = 50;
    localparam int EFFN_W     = EFF_W + NB_W;
    localparam int QM_W       = DIV_STEPS + SPB_W;
    localparam int MVAL_W     = QM_W - 23;

    localparam int PIPE_DEPTH = 4 + SQRT_STEPS + DIV_STEPS + 3;

    typedef struct packed {
        logic                    under_sea;
        logic [7:0]              sea_colour;
        logic                    lit;
        logic signed [31:0]      p;
        logic [D_W-1:0]          d;
        logic                    nneg;
        logic [PROD_W-1:0]       prod;
    } ctx_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [RAD_W-1:0]    rad;
        logic [ROOT_W-1:0]   root;
    } sqrt_lane_t;

    typedef struct packed {
        logic [DREM_W-1:0]    rem;
        logic [DIV_STEPS-1:0] nq;
        logic [DREM_W-1:0]    divisor;
    } div_lane_t;

endpackage

// ===== rtl/tps_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tps_sqrt_cell
// One root bit of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module tps_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tps_pkg::ctx_t       in_ctx,
    input  tps_pkg::sqrt_lane_t in_lane,
    output logic                out_valid,
    output tps_pkg::ctx_t       out_ctx,
    output tps_pkg::sqrt_lane_t out_lane
);

    logic                          valid_reg;
    tps_pkg::ctx_t                 ctx_reg;
    tps_pkg::sqrt_lane_t           lane_reg;
    tps_pkg::sqrt_lane_t           lane_next;
    logic [tps_pkg::SQ_REM_W+1:0]  acc;
    logic [tps_pkg::SQ_REM_W+1:0]  sub;
    logic                          ge;

    always_comb
    begin
        acc = {in_lane.rem, in_lane.rad[tps_pkg::RAD_W-1 -: 2]};
        sub = (tps_pkg::SQ_REM_W + 2)'({in_lane.root, 2'b01});
        ge  = (acc >= sub);
        lane_next.rad = {in_lane.rad[tps_pkg::RAD_W-3:0], 2'b00};
        if (ge)
        begin
            lane_next.rem  = tps_pkg::SQ_REM_W'(acc - sub);
            lane_next.root = {in_lane.root[tps_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = acc[tps_pkg::SQ_REM_W-1:0];
            lane_next.root = {in_lane.root[tps_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg  <= in_ctx;
        lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_lane  = lane_reg;

endmodule

// ===== rtl/tps_div_cell.sv =====
// ----------------------------------------------------------------------------
// tps_div_cell
// One quotient bit of two restoring divisions side by side, registered.
// ----------------------------------------------------------------------------
module tps_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tps_pkg::ctx_t      in_ctx,
    input  tps_pkg::div_lane_t in_t,
    input  tps_pkg::div_lane_t in_q,
    output logic               out_valid,
    output tps_pkg::ctx_t      out_ctx,
    output tps_pkg::div_lane_t out_t,
    output tps_pkg::div_lane_t out_q
);

    logic               valid_reg;
    tps_pkg::ctx_t      ctx_reg;
    tps_pkg::div_lane_t t_reg;
    tps_pkg::div_lane_t q_reg;

    function automatic tps_pkg::div_lane_t div_step(input tps_pkg::div_lane_t l);
        logic [tps_pkg::DREM_W:0] sh;
        logic                     ge;
        tps_pkg::div_lane_t       r;
        sh = {l.rem, l.nq[tps_pkg::DIV_STEPS-1]};
        ge = (sh >= {1'b0, l.divisor});
        r.divisor = l.divisor;
        r.nq      = {l.nq[tps_pkg::DIV_STEPS-2:0], ge};
        r.rem     = ge ? tps_pkg::DREM_W'(sh - {1'b0, l.divisor})
                       : sh[tps_pkg::DREM_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= in_ctx;
        t_reg   <= div_step(in_t);
        q_reg   <= div_step(in_q);
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_t     = t_reg;
    assign out_q     = q_reg;

endmodule

// ===== rtl/terrain_pixel_shader_core.sv =====
// ----------------------------------------------------------------------------
// terrain_pixel_shader_core
// Maps one terrain sample to a palette index through a row of root and
// divider cells.
// ----------------------------------------------------------------------------
// The core takes one sample in every clock cycle and busy never rises. Each
// result appears on done once its start beat has passed the registered
// slope and product stages, the 32 square root cells, the 48 divider cells
// and the band stages. Results come out in order, one per sample, and must
// be taken in the cycle they are shown.
module terrain_pixel_shader_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [31:0]                 height,
    input  logic signed [31:0]                 height_behind,
    input  logic signed [31:0]                 height_ahead,
    input  logic signed [31:0]                 shadow_height,
    output logic                               done,
    output logic [7:0]                         colour_index,
    output logic                               bad_angle,
    input  logic                               wr_en,
    input  logic [tps_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [31:0]                        wr_data
);

    logic signed [31:0] sea_level_reg;
    logic [30:0]        height_variance_reg;
    logic [15:0]        contour_weight_reg;
    logic [15:0]        shade_contrast_reg;
    logic signed [15:0] light_cos_reg;
    logic signed [15:0] light_sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_level_reg       <= 32'sd0;
            height_variance_reg <= 31'd65536;
            contour_weight_reg  <= 16'd77;
            shade_contrast_reg  <= 16'd256;
            light_cos_reg       <= 16'sd16384;
            light_sin_reg       <= 16'sd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tps_pkg::REG_SEA_LEVEL:       sea_level_reg       <= wr_data;
                tps_pkg::REG_HEIGHT_VARIANCE: height_variance_reg <= wr_data[30:0];
                tps_pkg::REG_CONTOUR_WEIGHT:  contour_weight_reg  <= wr_data[15:0];
                tps_pkg::REG_SHADE_CONTRAST:  shade_contrast_reg  <= wr_data[15:0];
                tps_pkg::REG_LIGHT_COS:       light_cos_reg       <= wr_data[15:0];
                tps_pkg::REG_LIGHT_SIN:       light_sin_reg       <= wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [tps_pkg::VC_W-1:0] vc_reg;

    always_ff @(posedge clk)
    begin
        vc_reg <= tps_pkg::VC_W'(height_variance_reg) * tps_pkg::VC_W'(contour_weight_reg);
    end

    // Front stages: slopes, squares, light term, D and the shade numerator.
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [31:0] s1_p_reg, s2_p_reg, s3_p_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic               s1_under_reg, s2_under_reg, s3_under_reg;
    logic [7:0]         s1_col_reg, s2_col_reg, s3_col_reg;
    logic               s1_lit_reg, s2_lit_reg, s3_lit_reg;
    logic [63:0]        s2_sqx_reg, s2_sqy_reg;
    logic signed [48:0] s2_n_reg;
    logic [tps_pkg::D_W-1:0]  s3_d_reg;
    logic [tps_pkg::NM_W-1:0] s3_nm_reg;
    logic               s3_nneg_reg;
    tps_pkg::ctx_t      s4_ctx_reg;
    tps_pkg::sqrt_lane_t s4_sq_reg;

    logic [31:0] dx_mag, dy_mag;

    assign dx_mag = s1_dx_reg[32] ? 32'(-s1_dx_reg) : s1_dx_reg[31:0];
    assign dy_mag = s1_dy_reg[32] ? 32'(-s1_dy_reg) : s1_dy_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg     <= height;
        s1_dx_reg    <= 33'(height) - 33'(height_behind);
        s1_dy_reg    <= 33'(height_ahead) - 33'(height);
        s1_under_reg <= (height < sea_level_reg);
        s1_col_reg   <= (shadow_height > sea_level_reg) ? 8'(tps_pkg::SEA_UNLIT_INDEX)
                                                        : 8'(tps_pkg::SEA_LIT_INDEX);
        s1_lit_reg   <= (height >= shadow_height);

        s2_p_reg     <= s1_p_reg;
        s2_under_reg <= s1_under_reg;
        s2_col_reg   <= s1_col_reg;
        s2_lit_reg   <= s1_lit_reg;
        s2_sqx_reg   <= 64'(dx_mag) * 64'(dx_mag);
        s2_sqy_reg   <= 64'(dy_mag) * 64'(dy_mag);
        s2_n_reg     <= 49'(s1_dx_reg) * 49'(light_cos_reg) + (49'(light_sin_reg) <<< 16);

        s3_p_reg     <= s2_p_reg;
        s3_under_reg <= s2_under_reg;
        s3_col_reg   <= s2_col_reg;
        s3_lit_reg   <= s2_lit_reg;
        s3_d_reg     <= tps_pkg::D_W'(65536) + tps_pkg::D_W'(s2_sqx_reg >> 16)
                        + tps_pkg::D_W'(s2_sqy_reg >> 16);
        s3_nm_reg    <= s2_n_reg[48] ? tps_pkg::NM_W'(-s2_n_reg)
                                     : s2_n_reg[tps_pkg::NM_W-1:0];
        s3_nneg_reg  <= s2_n_reg[48];

        s4_ctx_reg.under_sea  <= s3_under_reg;
        s4_ctx_reg.sea_colour <= s3_col_reg;
        s4_ctx_reg.lit        <= s3_lit_reg;
        s4_ctx_reg.p          <= s3_p_reg;
        s4_ctx_reg.d          <= s3_d_reg;
        s4_ctx_reg.nneg       <= s3_nneg_reg;
        s4_ctx_reg.prod       <= tps_pkg::PROD_W'(s3_nm_reg)
                                 * tps_pkg::PROD_W'(shade_contrast_reg);
        s4_sq_reg.rem         <= '0;
        s4_sq_reg.rad         <= {s3_d_reg, 14'd0};
        s4_sq_reg.root        <= '0;
    end

    // Square root row.
    logic                sq_valid [tps_pkg::SQRT_STEPS+1];
    tps_pkg::ctx_t       sq_ctx   [tps_pkg::SQRT_STEPS+1];
    tps_pkg::sqrt_lane_t sq_lane  [tps_pkg::SQRT_STEPS+1];

    assign sq_valid[0] = s4_valid_reg;
    assign sq_ctx[0]   = s4_ctx_reg;
    assign sq_lane[0]  = s4_sq_reg;

    for (genvar i = 0; i < tps_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        tps_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ctx    (sq_ctx[i]),
            .in_lane   (sq_lane[i]),
            .out_valid (sq_valid[i+1]),
            .out_ctx   (sq_ctx[i+1]),
            .out_lane  (sq_lane[i+1])
        );
    end

    // Divider row: effective height term and shade quotient.
    logic               dv_valid [tps_pkg::DIV_STEPS+1];
    tps_pkg::ctx_t      dv_ctx   [tps_pkg::DIV_STEPS+1];
    tps_pkg::div_lane_t dv_t     [tps_pkg::DIV_STEPS+1];
    tps_pkg::div_lane_t dv_q     [tps_pkg::DIV_STEPS+1];
    logic [tps_pkg::DIVD_W-1:0] t_dividend, q_dividend;

    assign t_dividend = tps_pkg::DIVD_W'({vc_reg, 8'd0});
    assign q_dividend = tps_pkg::DIVD_W'(sq_ctx[tps_pkg::SQRT_STEPS].prod);

    assign dv_valid[0]      = sq_valid[tps_pkg::SQRT_STEPS];
    assign dv_ctx[0]        = sq_ctx[tps_pkg::SQRT_STEPS];
    assign dv_t[0].rem      = tps_pkg::DREM_W'(t_dividend[tps_pkg::DIVD_W-1:tps_pkg::DIV_STEPS]);
    assign dv_t[0].nq       = t_dividend[tps_pkg::DIV_STEPS-1:0];
    assign dv_t[0].divisor  = sq_ctx[tps_pkg::SQRT_STEPS].d;
    assign dv_q[0].rem      = tps_pkg::DREM_W'(q_dividend[tps_pkg::DIVD_W-1:tps_pkg::DIV_STEPS]);
    assign dv_q[0].nq       = q_dividend[tps_pkg::DIV_STEPS-1:0];
    assign dv_q[0].divisor  = tps_pkg::DREM_W'(sq_lane[tps_pkg::SQRT_STEPS].root);

    for (genvar j = 0; j < tps_pkg::DIV_STEPS; j++)
    begin : g_div
        tps_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ctx    (dv_ctx[j]),
            .in_t      (dv_t[j]),
            .in_q      (dv_q[j]),
            .out_valid (dv_valid[j+1]),
            .out_ctx   (dv_ctx[j+1]),
            .out_t     (dv_t[j+1]),
            .out_q     (dv_q[j+1])
        );
    end

    // Back stages: effective height, band and shade, palette index.
    logic                              e1_valid_reg, e2_valid_reg;
    tps_pkg::ctx_t                     e1_ctx_reg, e2_ctx_reg;
    logic signed [tps_pkg::EFF_W-1:0]  e1_eff_reg;
    logic [tps_pkg::QM_W-1:0]          e1_qm_reg;
    logic signed [tps_pkg::EFFN_W-1:0] e2_effn_reg;
    logic [tps_pkg::SHADE_W-1:0]       e2_shade_reg;
    logic                              e2_flag_reg;
    logic                              done_reg;
    logic [7:0]                        colour_index_reg;
    logic                              bad_angle_reg;

    logic [tps_pkg::MVAL_W-1:0]  mval;
    logic [tps_pkg::SHADE_W-1:0] shade_next;
    logic                        flag_next;
    logic [tps_pkg::BAND_W-1:0]  band;
    logic [7:0]                  base_idx;
    logic [7:0]                  colour_next;

    always_comb
    begin
        mval = tps_pkg::MVAL_W'(e1_qm_reg >> 23);
        if (e1_ctx_reg.nneg)
        begin
            shade_next = '0;
            flag_next  = (mval != '0);
        end
        else
        begin
            flag_next  = 1'b0;
            shade_next = (mval > tps_pkg::MVAL_W'(tps_pkg::SHADES_PER_BAND - 1))
                         ? tps_pkg::SHADE_W'(tps_pkg::SHADES_PER_BAND - 1)
                         : tps_pkg::SHADE_W'(mval);
        end
    end

    always_comb
    begin
        band = '0;
        for (int k = 1; k < tps_pkg::NUM_BANDS; k++)
        begin
            if ((e2_effn_reg > 0) &&
                ($unsigned(e2_effn_reg) >= tps_pkg::EFFN_W'(height_variance_reg)
                                           * tps_pkg::EFFN_W'(k)))
            begin
                band = band + 1'b1;
            end
        end
        base_idx = 8'(tps_pkg::BAND_BASE_INDEX)
                   + 8'(16'(band) * 16'(tps_pkg::SHADES_PER_BAND));
        if (e2_ctx_reg.under_sea)
        begin
            colour_next = e2_ctx_reg.sea_colour;
        end
        else if (e2_ctx_reg.lit)
        begin
            colour_next = base_idx + 8'(e2_shade_reg);
        end
        else
        begin
            colour_next = base_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg     <= 1'b0;
            e2_valid_reg     <= 1'b0;
            done_reg         <= 1'b0;
            colour_index_reg <= '0;
            bad_angle_reg    <= 1'b0;
        end
        else
        begin
            e1_valid_reg     <= dv_valid[tps_pkg::DIV_STEPS];
            e2_valid_reg     <= e1_valid_reg;
            done_reg         <= e2_valid_reg;
            colour_index_reg <= colour_next;
            bad_angle_reg    <= e2_valid_reg && !e2_ctx_reg.under_sea
                                && e2_ctx_reg.lit && e2_flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_ctx_reg   <= dv_ctx[tps_pkg::DIV_STEPS];
        e1_eff_reg   <= tps_pkg::EFF_W'(dv_ctx[tps_pkg::DIV_STEPS].p)
                        + $signed(tps_pkg::EFF_W'(dv_t[tps_pkg::DIV_STEPS].nq));
        e1_qm_reg    <= tps_pkg::QM_W'(dv_q[tps_pkg::DIV_STEPS].nq)
                        * tps_pkg::QM_W'(tps_pkg::SHADES_PER_BAND);
        e2_ctx_reg   <= e1_ctx_reg;
        e2_effn_reg  <= tps_pkg::EFFN_W'(e1_eff_reg) * tps_pkg::EFFN_W'(tps_pkg::NUM_BANDS);
        e2_shade_reg <= shade_next;
        e2_flag_reg  <= flag_next;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign colour_index = colour_index_reg;
    assign bad_angle    = bad_angle_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(tps_pkg::PIPE_DEPTH) done)
        else $error("result beat missing after fixed latency");

    a_flag_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
        bad_angle |-> done)
        else $error("bad_angle raised outside a result beat");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Terrain pixel shader testbench
// Drives samples through the command port under several register settings.
// A scoreboard predicts each palette index and shading flag from the sample
// and the current registers, and compares every result beat in order.
// ----------------------------------------------------------------------------
class shade_scoreboard;

    typedef struct {
        logic [7:0] colour;
        logic       flag;
    } pixel_t;

    pixel_t              pending_pixels[$];
    int                  errors;
    longint              sea;
    longint unsigned     variance;
    longint unsigned     contour;
    longint unsigned     contrast;
    longint              lcos;
    longint              lsin;

    function new();
        errors   = 0;
        sea      = 0;
        variance = 65536;
        contour  = 77;
        contrast = 256;
        lcos     = 16384;
        lsin     = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] data);
        case (index)
            tps_pkg::REG_SEA_LEVEL:       sea = longint'($signed(data));
            tps_pkg::REG_HEIGHT_VARIANCE: variance = 64'(data[30:0]);
            tps_pkg::REG_CONTOUR_WEIGHT:  contour = 64'(data[15:0]);
            tps_pkg::REG_SHADE_CONTRAST:  contrast = 64'(data[15:0]);
            tps_pkg::REG_LIGHT_COS:       lcos = longint'($signed(data[15:0]));
            tps_pkg::REG_LIGHT_SIN:       lsin = longint'($signed(data[15:0]));
            default: ;
        endcase
    endfunction

    function longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    function void note(logic signed [31:0] p, logic signed [31:0] pb,
                       logic signed [31:0] pa, logic signed [31:0] sh);
        longint          dx, dy, eff, band, num;
        longint unsigned d, t, s, q, m, shade, idx;
        pixel_t          px;
        px.flag = 1'b0;
        if (longint'(p) < sea)
        begin
            px.colour = (longint'(sh) > sea) ? 8'(tps_pkg::SEA_UNLIT_INDEX)
                                             : 8'(tps_pkg::SEA_LIT_INDEX);
            pending_pixels.push_back(px);
            return;
        end
        dx  = longint'(p) - longint'(pb);
        dy  = longint'(pa) - longint'(p);
        d   = 65536 + ((magnitude(dx) * magnitude(dx)) >> 16)
                    + ((magnitude(dy) * magnitude(dy)) >> 16);
        t   = ((variance * contour) << 8) / d;
        eff = longint'(p) + longint'(t);
        if (variance == 0)
            band = (eff > 0) ? tps_pkg::NUM_BANDS - 1 : 0;
        else
            band = (eff * tps_pkg::NUM_BANDS) / longint'(variance);
        if (band < 0)
            band = 0;
        if (band > tps_pkg::NUM_BANDS - 1)
            band = tps_pkg::NUM_BANDS - 1;
        idx = tps_pkg::BAND_BASE_INDEX + band * tps_pkg::SHADES_PER_BAND;
        if (p >= sh)
        begin
            s   = floor_root(d << 14);
            num = dx * lcos + lsin * 65536;
            q   = (magnitude(num) * contrast) / s;
            m   = (q * tps_pkg::SHADES_PER_BAND) >> 23;
            if (num < 0)
            begin
                px.flag = (m != 0);
                shade   = 0;
            end
            else
                shade = (m > tps_pkg::SHADES_PER_BAND - 1)
                        ? tps_pkg::SHADES_PER_BAND - 1 : m;
            idx += shade;
        end
        px.colour = idx[7:0];
        pending_pixels.push_back(px);
    endfunction

    function void check(logic [7:0] colour, logic flag);
        pixel_t px;
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected result beat: colour_index %0d bad_angle %0d",
                   colour, flag);
            errors++;
            return;
        end
        px = pending_pixels.pop_front();
        if (colour !== px.colour)
        begin
            $error("colour_index: expected %0d, actual %0d", px.colour, colour);
            errors++;
        end
        if (flag !== px.flag)
        begin
            $error("bad_angle: expected %0d, actual %0d", px.flag, flag);
            errors++;
        end
    endfunction

endclass

module testbench;

    localparam logic [tps_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tps_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] height;
    logic signed [31:0] height_behind;
    logic signed [31:0] height_ahead;
    logic signed [31:0] shadow_height;
    logic               done;
    logic [7:0]         colour_index;
    logic               bad_angle;
    logic               wr_en;
    logic [tps_pkg::REG_IDX_W-1:0] wr_index;
    logic [31:0]        wr_data;

    shade_scoreboard    sb;
    int                 idle_cycles;
    bit                 no_gaps;

    terrain_pixel_shader_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .height        (height),
        .height_behind (height_behind),
        .height_ahead  (height_ahead),
        .shadow_height (shadow_height),
        .done          (done),
        .colour_index  (colour_index),
        .bad_angle     (bad_angle),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check(colour_index, bad_angle);
            if (start && !busy)
                sb.note(height, height_behind, height_ahead, shadow_height);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [tps_pkg::REG_IDX_W-1:0] index, logic [31:0] data);
        wr_en    = 1'b1;
        wr_index = index;
        wr_data  = data;
        sb.set_reg(index, data);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic set_regs(logic [31:0] sea, logic [31:0] variance,
                            logic [15:0] contour, logic [15:0] contrast,
                            logic [15:0] lcos, logic [15:0] lsin);
        write_reg(tps_pkg::REG_SEA_LEVEL, sea);
        write_reg(tps_pkg::REG_HEIGHT_VARIANCE, variance);
        write_reg(tps_pkg::REG_CONTOUR_WEIGHT, {16'($urandom_range(0, 65535)), contour});
        write_reg(tps_pkg::REG_SHADE_CONTRAST, {16'($urandom_range(0, 65535)), contrast});
        write_reg(tps_pkg::REG_LIGHT_COS, {16'($urandom_range(0, 65535)), lcos});
        write_reg(tps_pkg::REG_LIGHT_SIN, {16'($urandom_range(0, 65535)), lsin});
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
    endtask

    task automatic drain();
        while (sb.pending_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_pixel(logic [31:0] p, logic [31:0] pb,
                              logic [31:0] pa, logic [31:0] sh);
        bit taken;
        if (!no_gaps)
            repeat ($urandom_range(0, 15)) @(negedge clk);
        start         = 1'b1;
        height        = p;
        height_behind = pb;
        height_ahead  = pa;
        shadow_height = sh;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        start = 1'b0;
    endtask

    task automatic send_random();
        logic [31:0] p, pb, pa, sh;
        int          spread;
        if ($urandom_range(0, 9) == 0)
            send_pixel($urandom(), $urandom(), $urandom(), $urandom());
        else
        begin
            spread = $urandom_range(0, 3) == 0 ? 22 : 17;
            p  = 32'(sb.sea + $urandom_range(0, 32'h70000) - 32'h10000);
            if ($urandom_range(0, 7) == 0)
                p = 32'(sb.sea + $urandom_range(0, 32'h7fffffff));
            pb = p - ($urandom_range(0, 1 << spread) - (1 << (spread - 1)));
            pa = p + ($urandom_range(0, 1 << spread) - (1 << (spread - 1)));
            sh = ($urandom_range(0, 3) == 0) ? p + $urandom_range(1, 32'h40000)
                                             : p - $urandom_range(0, 32'h40000);
            send_pixel(p, pb, pa, sh);
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        start         = 1'b0;
        height        = '0;
        height_behind = '0;
        height_ahead  = '0;
        shadow_height = '0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        idle_cycles   = 0;
        no_gaps       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
        send_pixel(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_pixel(32'h80000000, 32'h0, 32'h0, 32'h80000000);
        send_pixel(32'h0, 32'h0, 32'h0, 32'h0);
        send_pixel(32'h8000, 32'h20000, 32'h8000, 32'h0);
        send_pixel(32'h8000, 32'h8010, 32'h8000, 32'h0);
        send_pixel(32'h8000, 32'h0, 32'h8000, 32'h0);
        send_pixel(32'h8000, 32'h0, 32'h8000, 32'h10000);
        send_pixel(32'h30000, 32'h2f000, 32'h31000, 32'h10000);
        send_pixel(32'hffffffff, 32'h0, 32'h0, 32'h0);
        send_pixel(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        drain();

        set_regs(32'h10000, 32'h1, 16'd0, 16'hffff, 16'hc000, 16'h4000);
        send_pixel(32'h10000, 32'h10000, 32'h10000, 32'h0);
        send_pixel(32'h0, 32'h0, 32'h0, 32'h20000);
        send_pixel(32'h0, 32'h0, 32'h0, 32'h0);
        send_pixel(32'h20000, 32'h30000, 32'h20000, 32'h0);
        drain();
        set_regs(32'h80000000, 32'h80000000, 16'hffff, 16'd0, 16'h4000, 16'hc000);
        send_pixel(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_pixel(32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0);
        send_pixel(32'hfff00000, 32'hfff00000, 32'hfff00000, 32'h80000000);
        drain();
        set_regs(32'h7fffffff, 32'h7fffffff, 16'hffff, 16'hffff, 16'h0, 16'h4000);
        send_pixel(32'h7fffffff, 32'h0, 32'h0, 32'h0);
        send_pixel(32'h7ffffffe, 32'h0, 32'h0, 32'h7fffffff);
        send_pixel(32'h7ffffffe, 32'h0, 32'h0, 32'h0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_regs(32'h0, 32'h10000, 16'd77, 16'd256, 16'h4000, 16'h0);
                1: set_regs(32'hfffe0000, 32'h40000, 16'd512, 16'd1024,
                            16'h2d41, 16'h2d41);
                2: set_regs(32'h0, 32'h1, 16'hffff, 16'hffff, 16'hc000, 16'h0);
                3: set_regs(32'h20000, 32'h7fffffff, 16'd0, 16'd64,
                            16'h3000, 16'hf000);
                4: set_regs(32'h0, 32'h80000000, 16'd300, 16'd800,
                            16'h4000, 16'h4000);
                5: set_regs($urandom(), $urandom(), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 32768) - 16384),
                            16'($urandom_range(0, 32768) - 16384));
                6: set_regs(32'h80000000, 32'h20000, 16'd1000, 16'd2000,
                            16'h1000, 16'hc000);
                default: set_regs(32'hffff0000, 32'h30000, 16'd100, 16'd400,
                                  16'h3800, 16'h1800);
            endcase
            no_gaps = (phase % 3 == 1);
            for (int n = 0; n < 110; n++)
            begin
                if (!no_gaps && $urandom_range(0, 15) == 0)
                    no_gaps = 1'b1;
                send_random();
            end
            drain();
        end

        drain();
        repeat (100) @(negedge clk);
        if (sb.pending_pixels.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_pixels.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tps_pkg.sv
rtl/tps_sqrt_cell.sv
rtl/tps_div_cell.sv
rtl/terrain_pixel_shader_core.sv
tb/sv/testbench.sv
